>>> rtl/tmcw_pkg.sv
// tmcw_pkg: shared types and constants for the text-mode console writer
// holds the command record passed from the front end to the back end
// no dependencies
package tmcw_pkg;

	// command classes decided at the front end
	typedef enum logic [1:0] {
		CMD_READ,
		CMD_CHAR,
		CMD_NEWLINE,
		CMD_BACKSPACE
	} cmd_kind_t;

	// one queued command
	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  code;
		logic [10:0] index;
	} cmd_t;

	// back end sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RDATA,
		ST_SCROLL,
		ST_ZERO,
		ST_BLANK,
		ST_ECHO2,
		ST_ECHO3
	} back_state_t;

	localparam int          CELL_W         = 16;
	localparam logic        OPC_READ       = 1'b1;
	localparam logic [8:0]  CODE_BACKSPACE = 9'd256;
	localparam logic [7:0]  CODE_NEWLINE   = 8'd10;
	localparam logic [7:0]  CHAR_SPACE     = 8'h20;
	localparam logic [7:0]  CHAR_BS        = 8'h08;
	localparam logic [7:0]  ATTR_RESET     = 8'h07;

endpackage

>>> rtl/tmcw_ram.sv
// tmcw_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module tmcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1920
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/tmcw_front.sv
// tmcw_front: accepts items, classifies them and holds them in a two-entry queue
// depends on tmcw_pkg
module tmcw_front import tmcw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        opcode,
	input  logic [8:0]  char_code,
	input  logic [10:0] cell_index,
	input  logic        hold,
	output logic        busy,
	output logic        head_valid,
	output cmd_t        head_cmd,
	input  logic        pop
);

	cmd_t       in_cmd;
	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	// classify the incoming item
	always_comb begin
		in_cmd.code  = char_code[7:0];
		in_cmd.index = cell_index;
		if (opcode == OPC_READ) begin
			in_cmd.kind = CMD_READ;
		end else if (char_code == CODE_BACKSPACE) begin
			in_cmd.kind = CMD_BACKSPACE;
		end else if (char_code[7:0] == CODE_NEWLINE) begin
			in_cmd.kind = CMD_NEWLINE;
		end else begin
			in_cmd.kind = CMD_CHAR;
		end
	end

	assign busy       = hold || (count_q == 2'd2);
	assign push       = start && !busy;
	assign head_valid = (count_q != 2'd0);
	assign head_cmd   = entry_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_cmd;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/tmcw_back.sv
// tmcw_back: sequencer that carries out queued commands on the screen memory
// depends on tmcw_pkg and tmcw_ram
module tmcw_back import tmcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  cmd_t        head_cmd,
	output logic        pop,
	input  logic [7:0]  attr,
	output logic        clearing,
	output logic        result_valid,
	output logic [7:0]  serial_byte,
	output logic        serial_valid,
	output logic [15:0] cell_data,
	output logic [10:0] cursor_position,
	output logic        last
);

	localparam int CELLS     = COLUMNS * ROWS;
	localparam int AW        = $clog2(CELLS);
	localparam int CW        = $clog2(COLUMNS);
	localparam int RW        = $clog2(ROWS);
	localparam int ZERO_BASE = (ROWS - 1) * COLUMNS;

	back_state_t       state_q, state_d;
	logic [AW-1:0]     cur_q, nlin;
	logic [RW-1:0]     row_q, nrow;
	logic [CW-1:0]     col_q, ncol;
	logic [AW-1:0]     cnt_q;
	logic              copy_wr_q;
	logic [AW-1:0]     copy_dst_q;
	logic              in_range_q;
	cmd_kind_t         kind_q;
	logic [7:0]        code_q;
	logic              wrap, scroll;
	logic              at_last_col, at_last_row;
	logic [31:0]       cur_ext;

	// memory port controls
	logic              we;
	logic [AW-1:0]     waddr, raddr;
	logic [CELL_W-1:0] wdata, rdata;

	// result controls
	logic              emit, emit_sv, emit_last;
	logic [7:0]        emit_byte;
	logic [15:0]       emit_cell;

	logic              res_valid_q, ser_valid_q, last_q;
	logic [7:0]        ser_byte_q;
	logic [15:0]       cell_q;
	logic [10:0]       cur_out_q;

	tmcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_screen (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// next cursor for the command at the queue head
	always_comb begin
		at_last_col = (col_q == CW'(COLUMNS - 1));
		at_last_row = (row_q == RW'(ROWS - 1));
		wrap = 1'b0;
		nrow = row_q;
		ncol = col_q;
		nlin = cur_q;
		case (head_cmd.kind)
			CMD_CHAR: begin
				if (at_last_col) begin
					wrap = 1'b1;
				end else begin
					ncol = col_q + CW'(1);
					nlin = cur_q + AW'(1);
				end
			end
			CMD_NEWLINE: begin
				wrap = 1'b1;
			end
			CMD_BACKSPACE: begin
				if (cur_q != '0) begin
					nlin = cur_q - AW'(1);
					if (col_q == '0) begin
						nrow = row_q - RW'(1);
						ncol = CW'(COLUMNS - 1);
					end else begin
						ncol = col_q - CW'(1);
					end
				end
			end
			default: begin
			end
		endcase
		scroll = wrap && at_last_row;
		if (wrap) begin
			ncol = '0;
			if (at_last_row) begin
				nrow = row_q;
				nlin = AW'(ZERO_BASE);
			end else begin
				nrow = row_q + RW'(1);
				nlin = AW'(32'(cur_q) + COLUMNS - 32'(col_q));
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (32'(cnt_q) == CELLS - 1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (head_valid) begin
					if (head_cmd.kind == CMD_READ) begin
						state_d = ST_RDATA;
					end else if (scroll) begin
						state_d = ST_SCROLL;
					end else begin
						state_d = ST_BLANK;
					end
				end
			end
			ST_RDATA: state_d = ST_IDLE;
			ST_SCROLL: begin
				if (32'(cnt_q) == ZERO_BASE - 1) begin
					state_d = ST_ZERO;
				end
			end
			ST_ZERO: begin
				if (!copy_wr_q && 32'(cnt_q) == CELLS - 1) begin
					state_d = ST_BLANK;
				end
			end
			ST_BLANK: begin
				if (kind_q == CMD_BACKSPACE) begin
					state_d = ST_ECHO2;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_ECHO2: state_d = ST_ECHO3;
			ST_ECHO3: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// memory and result controls
	always_comb begin
		we        = 1'b0;
		waddr     = cur_q;
		wdata     = '0;
		raddr     = AW'(head_cmd.index);
		pop       = 1'b0;
		emit      = 1'b0;
		emit_sv   = 1'b1;
		emit_last = 1'b0;
		emit_byte = '0;
		emit_cell = '0;
		case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = cnt_q;
			end
			ST_IDLE: begin
				pop = head_valid;
				if (head_valid && head_cmd.kind == CMD_CHAR) begin
					we    = 1'b1;
					wdata = {attr, head_cmd.code};
				end
			end
			ST_RDATA: begin
				emit      = 1'b1;
				emit_sv   = 1'b0;
				emit_last = 1'b1;
				emit_cell = in_range_q ? rdata : '0;
			end
			ST_SCROLL: begin
				raddr = AW'(32'(cnt_q) + COLUMNS);
				we    = copy_wr_q;
				waddr = copy_dst_q;
				wdata = rdata;
			end
			ST_ZERO: begin
				we = 1'b1;
				if (copy_wr_q) begin
					waddr = copy_dst_q;
					wdata = rdata;
				end else begin
					waddr = cnt_q;
				end
			end
			ST_BLANK: begin
				we        = 1'b1;
				wdata     = {attr, CHAR_SPACE};
				emit      = 1'b1;
				emit_byte = (kind_q == CMD_BACKSPACE) ? CHAR_BS : code_q;
				emit_last = (kind_q != CMD_BACKSPACE);
			end
			ST_ECHO2: begin
				emit      = 1'b1;
				emit_byte = CHAR_SPACE;
			end
			ST_ECHO3: begin
				emit      = 1'b1;
				emit_byte = CHAR_BS;
				emit_last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// sequencer registers and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			cnt_q     <= '0;
			copy_wr_q <= 1'b0;
			cur_q     <= '0;
			row_q     <= '0;
			col_q     <= '0;
		end else begin
			state_q   <= state_d;
			copy_wr_q <= 1'b0;
			case (state_q)
				ST_CLEAR: cnt_q <= cnt_q + AW'(1);
				ST_IDLE: begin
					cnt_q <= '0;
					if (head_valid && head_cmd.kind != CMD_READ) begin
						cur_q <= nlin;
						row_q <= nrow;
						col_q <= ncol;
					end
				end
				ST_SCROLL: begin
					cnt_q     <= cnt_q + AW'(1);
					copy_wr_q <= 1'b1;
				end
				ST_ZERO: begin
					if (!copy_wr_q) begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// command payload and copy address
	always_ff @(posedge clk) begin
		copy_dst_q <= cnt_q;
		if (state_q == ST_IDLE && head_valid) begin
			kind_q     <= head_cmd.kind;
			code_q     <= head_cmd.code;
			in_range_q <= (32'(head_cmd.index) < CELLS);
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= emit;
		end
	end

	assign cur_ext = 32'(cur_q);

	// result payload
	always_ff @(posedge clk) begin
		if (emit) begin
			ser_byte_q  <= emit_byte;
			ser_valid_q <= emit_sv;
			cell_q      <= emit_cell;
			cur_out_q   <= cur_ext[10:0];
			last_q      <= emit_last;
		end
	end

	assign clearing        = (state_q == ST_CLEAR);
	assign result_valid    = res_valid_q;
	assign serial_byte     = ser_byte_q;
	assign serial_valid    = ser_valid_q;
	assign cell_data       = cell_q;
	assign cursor_position = cur_out_q;
	assign last            = last_q;

`ifndef SYNTHESIS
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cur_q) < CELLS)
		else $error("cursor outside the screen");

	a_cursor_rowcol: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cur_q) == 32'(row_q) * COLUMNS + 32'(col_q))
		else $error("cursor row and column disagree with cell index");

	a_echo_burst: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !last_q |=> res_valid_q)
		else $error("backspace echo burst broken");

	a_pop_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");
`endif

endmodule

>>> rtl/text_mode_console_writer_core.sv
// text_mode_console_writer_core: text screen writer, front end queue plus back end sequencer
// an accepted item is stored in the two-entry queue, the sequencer takes it in its idle state,
// and the result strobe and payload are registered
// a new put or read is accepted while earlier ones are still carried out, as long as the queue has room;
// results cannot be stalled; reset: busy stays high while the screen is cleared
module text_mode_console_writer_core import tmcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic [8:0]  char_code,
	input  logic [10:0] cell_index,
	input  logic        cfg_write,
	input  logic [7:0]  cfg_wdata,
	output logic        result_valid,
	output logic [7:0]  serial_byte,
	output logic        serial_valid,
	output logic [15:0] cell_data,
	output logic [10:0] cursor_position,
	output logic        last
);

	logic [7:0] text_attribute_q;
	logic       clearing;
	logic       head_valid;
	cmd_t       head_cmd;
	logic       pop;

	// attribute register, resets to 0x07
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attribute_q <= ATTR_RESET;
		end else if (cfg_write) begin
			text_attribute_q <= cfg_wdata;
		end
	end

	tmcw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.opcode     (opcode),
		.char_code  (char_code),
		.cell_index (cell_index),
		.hold       (clearing),
		.busy       (busy),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop)
	);

	tmcw_back #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head_valid      (head_valid),
		.head_cmd        (head_cmd),
		.pop             (pop),
		.attr            (text_attribute_q),
		.clearing        (clearing),
		.result_valid    (result_valid),
		.serial_byte     (serial_byte),
		.serial_valid    (serial_valid),
		.cell_data       (cell_data),
		.cursor_position (cursor_position),
		.last            (last)
	);

endmodule
